// ----- sv/tce_pkg.sv -----
// Shared types, widths and constants for the tricorn escape-time pixel unit.
// No dependencies; every other file imports this package.
`default_nettype none
package tce_pkg;

  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 20;
  localparam int COUNT_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int STEP_W     = 31;
  localparam int FIX_W      = 32;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int FRAC_BITS  = 26;
  localparam int FRAME_WIDTH = 1024;

  localparam logic [COLOR_W-1:0] COLOR_MUL = 32'd189979;

  localparam logic [STEP_W-1:0]        SCALE_STEP_RST = 31'd268435;
  localparam logic signed [FIX_W-1:0]  ORIGIN_RE_RST  = -32'sd140509184;
  localparam logic signed [FIX_W-1:0]  ORIGIN_IM_RST  = -32'sd80530636;
  localparam logic [COUNT_W-1:0]       ITER_LIMIT_RST = 12'd50;

  typedef enum logic [1:0] {
    REG_SCALE_STEP,
    REG_ORIGIN_RE,
    REG_ORIGIN_IM,
    REG_ITER_LIMIT
  } tce_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE,
    S_CIM,
    S_INIT,
    S_TEST,
    S_SQIM,
    S_CROSS,
    S_UPD,
    S_COLOR,
    S_DONE
  } tce_state_t;

  typedef struct packed {
    logic [STEP_W-1:0]       scale_step;
    logic signed [FIX_W-1:0] origin_re;
    logic signed [FIX_W-1:0] origin_im;
    logic [COUNT_W-1:0]      iter_limit;
  } tce_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_addr;
    logic [COUNT_W-1:0] iter_count;
    logic               escaped;
    logic [COLOR_W-1:0] pixel_color;
  } tce_res_t;

endpackage
`default_nettype wire

// ----- sv/tce_if.sv -----
// Request and result channel interfaces with valid/ready handshake.
// Depends on tce_pkg for field widths.
`default_nettype none
interface tce_req_if;
  import tce_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface tce_rsp_if;
  import tce_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  frame_addr;
  logic [COUNT_W-1:0] iter_count;
  logic               escaped;
  logic [COLOR_W-1:0] pixel_color;
  modport source (output valid, frame_addr, iter_count, escaped, pixel_color, input ready);
  modport sink   (input valid, frame_addr, iter_count, escaped, pixel_color, output ready);
endinterface
`default_nettype wire

// ----- sv/tce_core.sv -----
// Iteration engine: sequencer around one shared 32x32 signed multiplier.
// Forms c, iterates the tricorn map, then forms address and color. Uses tce_pkg.
`default_nettype none
module tce_core #(
  parameter int FRAME_WIDTH = tce_pkg::FRAME_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tce_pkg::tce_cfg_t            cfg,
  input  wire logic                         start,
  input  wire logic [tce_pkg::COORD_W-1:0]  col_in,
  input  wire logic [tce_pkg::COORD_W-1:0]  row_in,
  output      logic                         idle,
  output      logic                         res_valid,
  input  wire logic                         res_ready,
  output      tce_pkg::tce_res_t            res
);
  import tce_pkg::*;

  localparam int Z_W   = FIX_W + 1;
  localparam int SQ_W  = 56;
  localparam int SML_W = FRAC_BITS + 2;
  localparam logic signed [Z_W-1:0] Z_TWO   = 33'sd1 <<< (FRAC_BITS + 1);
  localparam logic [SQ_W-1:0]       ESC_Q52 = 56'd4 << (2 * FRAC_BITS);
  localparam logic [ADDR_W-1:0]     FW_A    = ADDR_W'(FRAME_WIDTH);

  tce_state_t state_r, state_nxt;

  logic [COORD_W-1:0]       col_r, col_nxt, row_r, row_nxt;
  logic signed [FIX_W-1:0]  c_re_r, c_re_nxt, c_im_r, c_im_nxt;
  logic signed [Z_W-1:0]    re_r, re_nxt, im_r, im_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic [SQ_W-1:0]          re2_r, re2_nxt;
  logic signed [SQ_W-1:0]   diff_r, diff_nxt;
  logic                     mag_ge_r, mag_ge_nxt;

  logic signed [31:0]       mul_a, mul_b;
  logic signed [31:0]       re_op, im_op;
  logic                     re_small, im_small;
  logic [SQ_W-1:0]          mag;
  logic signed [SQ_W-1:0]   re_q, neg_p, im_q;

  function automatic logic signed [FIX_W-1:0] sat32(
    input logic signed [FIX_W-1:0] org,
    input logic [41:0]             off
  );
    logic signed [42:0] s;
    s = 43'(org) + $signed({1'b0, off});
    if (s > 43'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (s < -43'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[FIX_W-1:0];
  endfunction

  assign re_small = (re_r < Z_TWO) && (re_r > -Z_TWO);
  assign im_small = (im_r < Z_TWO) && (im_r > -Z_TWO);
  assign re_op    = 32'($signed(re_r[SML_W-1:0]));
  assign im_op    = 32'($signed(im_r[SML_W-1:0]));
  assign mag      = re2_r + prod_r[SQ_W-1:0];
  assign re_q     = diff_r >>> FRAC_BITS;
  assign neg_p    = -$signed(prod_r[SQ_W-1:0]);
  assign im_q     = neg_p >>> (FRAC_BITS - 1);

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    c_re_nxt   = c_re_r;
    c_im_nxt   = c_im_r;
    re_nxt     = re_r;
    im_nxt     = im_r;
    count_nxt  = count_r;
    re2_nxt    = re2_r;
    diff_nxt   = diff_r;
    mag_ge_nxt = mag_ge_r;
    mul_a      = '0;
    mul_b      = '0;
    idle       = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          col_nxt   = col_in;
          row_nxt   = row_in;
          state_nxt = S_CRE;
        end
      end
      S_CRE: begin
        mul_a     = $signed({1'b0, cfg.scale_step});
        mul_b     = $signed({22'd0, col_r});
        state_nxt = S_CIM;
      end
      S_CIM: begin
        mul_a     = $signed({1'b0, cfg.scale_step});
        mul_b     = $signed({22'd0, row_r});
        c_re_nxt  = sat32(cfg.origin_re, prod_r[41:0]);
        state_nxt = S_INIT;
      end
      S_INIT: begin
        c_im_nxt  = sat32(cfg.origin_im, prod_r[41:0]);
        re_nxt    = '0;
        im_nxt    = '0;
        count_nxt = '0;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        mul_a = re_op;
        mul_b = re_op;
        if (!re_small || !im_small || count_r >= cfg.iter_limit) begin
          state_nxt = S_COLOR;
        end else begin
          state_nxt = S_SQIM;
        end
      end
      S_SQIM: begin
        mul_a     = im_op;
        mul_b     = im_op;
        re2_nxt   = prod_r[SQ_W-1:0];
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        mul_a      = re_op;
        mul_b      = im_op;
        mag_ge_nxt = (mag >= ESC_Q52);
        diff_nxt   = $signed(re2_r) - $signed(prod_r[SQ_W-1:0]);
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        if (mag_ge_r) begin
          state_nxt = S_COLOR;
        end else begin
          re_nxt    = Z_W'(re_q) + Z_W'(c_re_r);
          im_nxt    = Z_W'(im_q) + Z_W'(c_im_r);
          count_nxt = count_r + 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_COLOR: begin
        mul_a     = $signed({20'd0, count_r});
        mul_b     = $signed(COLOR_MUL);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign prod_nxt = (state_r == S_DONE) ? prod_r : 64'(mul_a) * 64'(mul_b);

  always_comb begin
    res.frame_addr  = ADDR_W'(col_r) + ADDR_W'(row_r) * FW_A;
    res.iter_count  = count_r;
    res.escaped     = (count_r != cfg.iter_limit);
    res.pixel_color = res.escaped ? prod_r[COLOR_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    c_re_r   <= c_re_nxt;
    c_im_r   <= c_im_nxt;
    re_r     <= re_nxt;
    im_r     <= im_nxt;
    count_r  <= count_nxt;
    prod_r   <= prod_nxt;
    re2_r    <= re2_nxt;
    diff_r   <= diff_nxt;
    mag_ge_r <= mag_ge_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/tricorn_escape_time_pixel.sv -----
// Top level: APB register file, iteration engine and result output register.
// Depends on tce_pkg, tce_req_if/tce_rsp_if and tce_core.
//
//   channel   dir   handshake          payload
//   in_req    in    valid/ready        pixel_col, pixel_row
//   out_rsp   out   valid/ready        frame_addr, iter_count, escaped, pixel_color
//   APB       in    psel/penable/pready scale_step, origin_re, origin_im, iteration_limit
//
// An accepted request forms c, then iterates through S_TEST, S_SQIM, S_CROSS and S_UPD,
// using the shared 32x32 multiplier in the first three. The limit or a component of
// size 2 or more ends the iterations in S_TEST, the |z|^2 >= 4 compare in S_UPD.
// The result then passes S_COLOR and S_DONE; the next request is taken after S_DONE.
// Reset is synchronous, active low; it resets only the state, config and output valid registers.
// A full output register with out_rsp.ready low holds the engine in its last state.
`default_nettype none
module tricorn_escape_time_pixel #(
  parameter int FRAME_WIDTH = tce_pkg::FRAME_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  tce_req_if.sink                          in_req,
  tce_rsp_if.source                        out_rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tce_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [tce_pkg::CFG_DW-1:0]  pwdata,
  output      logic [tce_pkg::CFG_DW-1:0]  prdata,
  output      logic                        pready
);
  import tce_pkg::*;

  tce_cfg_t cfg_r;
  tce_res_t res, out_r;
  tce_reg_t reg_sel;
  logic     wr_en, core_idle, res_valid, res_take, out_valid_r;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = tce_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_step <= SCALE_STEP_RST;
      cfg_r.origin_re  <= ORIGIN_RE_RST;
      cfg_r.origin_im  <= ORIGIN_IM_RST;
      cfg_r.iter_limit <= ITER_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SCALE_STEP: cfg_r.scale_step <= pwdata[STEP_W-1:0];
        REG_ORIGIN_RE:  cfg_r.origin_re  <= $signed(pwdata);
        REG_ORIGIN_IM:  cfg_r.origin_im  <= $signed(pwdata);
        REG_ITER_LIMIT: cfg_r.iter_limit <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCALE_STEP: prdata = {1'b0, cfg_r.scale_step};
      REG_ORIGIN_RE:  prdata = cfg_r.origin_re;
      REG_ORIGIN_IM:  prdata = cfg_r.origin_im;
      REG_ITER_LIMIT: prdata = {20'd0, cfg_r.iter_limit};
      default:        prdata = '0;
    endcase
  end

  assign in_req.ready = core_idle;
  assign res_take     = res_valid & (~out_valid_r | out_rsp.ready);

  tce_core #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_req.valid & core_idle),
    .col_in    (in_req.pixel_col),
    .row_in    (in_req.pixel_row),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.frame_addr  = out_r.frame_addr;
  assign out_rsp.iter_count  = out_r.iter_count;
  assign out_rsp.escaped     = out_r.escaped;
  assign out_rsp.pixel_color = out_r.pixel_color;

endmodule
`default_nettype wire

// ----- sv/tce_checker.sv -----
// Port-level checks for the tricorn escape-time pixel unit, bound to the top.
// Depends on tce_pkg and tricorn_escape_time_pixel.
`default_nettype none
module tce_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [tce_pkg::ADDR_W-1:0]   frame_addr,
  input wire logic [tce_pkg::COUNT_W-1:0]  iter_count,
  input wire logic                         escaped,
  input wire logic [tce_pkg::COLOR_W-1:0]  pixel_color
);
  import tce_pkg::*;

  logic [COLOR_W-1:0] exp_color;
  assign exp_color = escaped ? 32'(32'(iter_count) * COLOR_MUL) : '0;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_addr) && $stable(iter_count)
      && $stable(escaped) && $stable(pixel_color))
    else $error("result dropped or changed while stalled");

  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pixel_color == exp_color)
    else $error("color does not match count and escape flag");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request taken while engine busy");

endmodule

bind tricorn_escape_time_pixel tce_checker u_tce_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .frame_addr  (out_rsp.frame_addr),
  .iter_count  (out_rsp.iter_count),
  .escaped     (out_rsp.escaped),
  .pixel_color (out_rsp.pixel_color)
);
`default_nettype wire
